>>> design/vrp_pkg.sv
package vrp_pkg;

   // fixed-point formats
   localparam int COORD_FRAC_BITS = 16;
   localparam int TRIG_BITS       = 18;
   localparam int ANGLE_BITS      = 16;
   localparam int TRIG_FRAC       = TRIG_BITS - 2;

   // field widths
   localparam int IN_W        = 32;
   localparam int OUT_W       = 32;
   localparam int ANGLE_REG_W = 16;
   localparam int FOV_W       = 24;
   localparam int CAM_W       = 31;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   // rotated coordinates grow by two bits
   localparam int COORD_W = IN_W + 2;
   localparam int MUL_W   = COORD_W + TRIG_BITS;
   localparam int DEP_W   = COORD_W + 2;

   // projection datapath
   localparam int PROD_W = COORD_W + FOV_W + 1;
   localparam int MAG_W  = PROD_W - 1;
   localparam int NUM_W  = MAG_W + COORD_FRAC_BITS - 8;
   localparam int QB     = OUT_W + 1;

   // cordic
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 34;
   localparam int STEP_W       = 5;
   localparam int NUM_AXES     = 3;
   localparam int CORDIC_GAIN  = 652032874;

   // pipeline depth
   localparam int ROT_LAT  = 6;
   localparam int LANE_LAT = QB + 3;
   localparam int PIPE_LAT = 1 + ROT_LAT + LANE_LAT;

   typedef logic signed [COORD_W-1:0]   coord_type;
   typedef logic signed [TRIG_BITS-1:0] trig_val_type;

   typedef struct packed {
      trig_val_type cos_x;
      trig_val_type sin_x;
      trig_val_type cos_y;
      trig_val_type sin_y;
      trig_val_type cos_z;
      trig_val_type sin_z;
   } trig_type;

   typedef struct packed {
      logic [ANGLE_REG_W-1:0] x;
      logic [ANGLE_REG_W-1:0] y;
      logic [ANGLE_REG_W-1:0] z;
   } angles_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] screen_x;
      logic signed [OUT_W-1:0] screen_y;
      logic                    depth_invalid;
      logic                    overflowed;
   } result_type;

   typedef enum logic [2:0] {
      REG_ANGLE_X,
      REG_ANGLE_Y,
      REG_ANGLE_Z,
      REG_FOV_FACTOR,
      REG_PROJECTION_MODE,
      REG_CAMERA_OFFSET
   } reg_index_type;

   // atan(2^-i) in units of one turn / 2^32
   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         5'd24:   v = 32'd41;
         5'd25:   v = 32'd20;
         5'd26:   v = 32'd10;
         5'd27:   v = 32'd5;
         5'd28:   v = 32'd3;
         5'd29:   v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

>>> design/vrp_trig.sv
module vrp_trig (
   input  logic                clock,
   input  logic                reset,
   input  vrp_pkg::angles_type angles,
   input  logic                angle_wr,
   output vrp_pkg::trig_type   coefs,
   output logic                ready
);
   import vrp_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_ITER, ST_STORE} state_type;

   localparam int RS = 30 - TRIG_FRAC;
   localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 1 <<< (RS - 1);
   localparam logic signed [CORDIC_W-1:0] TRIG_ONE   = 1 <<< TRIG_FRAC;
   localparam logic signed [CORDIC_W-1:0] GAIN       = CORDIC_GAIN;

   state_type                  state_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [1:0]                 axis_ff;
   logic                       ready_ff;
   logic [1:0]                 quad_ff;
   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff;
   trig_val_type               coef_ff [2*NUM_AXES];

   logic [ANGLE_REG_W-1:0]     angle_sel;
   logic [31:0]                a32;
   logic signed [CORDIC_W-1:0] dx, dy, at;
   logic signed [CORDIC_W-1:0] x_in, y_in, z_in;
   trig_val_type               c_rnd, s_rnd, cos_in, sin_in;

   function automatic trig_val_type round_trig(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] r;
      r = (v + ROUND_HALF) >>> RS;
      if (r > TRIG_ONE) r = TRIG_ONE;
      if (r < -TRIG_ONE) r = -TRIG_ONE;
      return TRIG_BITS'(r);
   endfunction

   always_comb begin
      case (axis_ff)
         2'd0:    angle_sel = angles.x;
         2'd1:    angle_sel = angles.y;
         default: angle_sel = angles.z;
      endcase
      a32 = {angle_sel[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
   end

   // one micro-rotation per cycle
   always_comb begin
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      at = signed'({{(CORDIC_W-32){1'b0}}, atan_turn(step_ff)});
      if (!z_ff[CORDIC_W-1]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   // rounding and quadrant fold
   always_comb begin
      c_rnd = round_trig(x_ff);
      s_rnd = round_trig(y_ff);
      case (quad_ff)
         2'd0: begin
            cos_in = c_rnd;
            sin_in = s_rnd;
         end
         2'd1: begin
            cos_in = -s_rnd;
            sin_in = c_rnd;
         end
         2'd2: begin
            cos_in = -c_rnd;
            sin_in = -s_rnd;
         end
         default: begin
            cos_in = s_rnd;
            sin_in = -c_rnd;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         step_ff  <= '0;
         axis_ff  <= '0;
      end else if (angle_wr) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (!ready_ff) begin
                  axis_ff  <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               x_ff     <= GAIN;
               y_ff     <= '0;
               z_ff     <= signed'({{(CORDIC_W-30){1'b0}}, a32[29:0]});
               quad_ff  <= a32[31:30];
               step_ff  <= '0;
               state_ff <= ST_ITER;
            end
            ST_ITER: begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= z_in;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_STORE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_STORE: begin
               coef_ff[{axis_ff, 1'b0}] <= cos_in;
               coef_ff[{axis_ff, 1'b1}] <= sin_in;
               if (axis_ff == 2'(NUM_AXES - 1)) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_LOAD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign coefs.cos_x = coef_ff[0];
   assign coefs.sin_x = coef_ff[1];
   assign coefs.cos_y = coef_ff[2];
   assign coefs.sin_y = coef_ff[3];
   assign coefs.cos_z = coef_ff[4];
   assign coefs.sin_z = coef_ff[5];
   assign ready       = ready_ff;

endmodule

>>> design/vrp_rotate.sv
module vrp_rotate (
   input  logic                  clock,
   input  logic                  en,
   input  vrp_pkg::coord_type    a_i,
   input  vrp_pkg::coord_type    b_i,
   input  vrp_pkg::coord_type    pass_i,
   input  vrp_pkg::trig_val_type cos_i,
   input  vrp_pkg::trig_val_type sin_i,
   input  logic                  bypass_i,
   output vrp_pkg::coord_type    a_o,
   output vrp_pkg::coord_type    b_o,
   output vrp_pkg::coord_type    pass_o
);
   import vrp_pkg::*;

   localparam logic signed [MUL_W:0] HALF = 1 <<< (TRIG_FRAC - 1);

   logic signed [MUL_W-1:0] p_ac_ff, p_bs_ff, p_bc_ff, p_as_ff;
   coord_type               a1_ff, b1_ff, pass1_ff;
   logic                    byp1_ff;
   coord_type               a2_ff, b2_ff, pass2_ff;
   logic signed [MUL_W:0]   sum_a, sum_b;
   coord_type               a_in, b_in;

   // stage 1: four products
   always_ff @(posedge clock) begin
      if (en) begin
         p_ac_ff  <= a_i * cos_i;
         p_bs_ff  <= b_i * sin_i;
         p_bc_ff  <= b_i * cos_i;
         p_as_ff  <= a_i * sin_i;
         a1_ff    <= a_i;
         b1_ff    <= b_i;
         pass1_ff <= pass_i;
         byp1_ff  <= bypass_i;
      end
   end

   // stage 2: combine, round half up, bypass for a zero angle
   always_comb begin
      sum_a = (MUL_W+1)'(p_ac_ff) - (MUL_W+1)'(p_bs_ff) + HALF;
      sum_b = (MUL_W+1)'(p_bc_ff) + (MUL_W+1)'(p_as_ff) + HALF;
      if (byp1_ff) begin
         a_in = a1_ff;
         b_in = b1_ff;
      end else begin
         a_in = COORD_W'(sum_a >>> TRIG_FRAC);
         b_in = COORD_W'(sum_b >>> TRIG_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff    <= a_in;
         b2_ff    <= b_in;
         pass2_ff <= pass1_ff;
      end
   end

   assign a_o    = a2_ff;
   assign b_o    = b2_ff;
   assign pass_o = pass2_ff;

endmodule

>>> design/vrp_lane.sv
module vrp_lane (
   input  logic                           clock,
   input  logic                           en,
   input  vrp_pkg::coord_type             coord_i,
   input  logic [vrp_pkg::DEP_W-1:0]      depth_i,
   input  logic                           persp_i,
   input  logic [vrp_pkg::FOV_W-1:0]      fov_i,
   output logic signed [vrp_pkg::OUT_W-1:0] result_o,
   output logic                           ovf_o
);
   import vrp_pkg::*;

   localparam logic signed [PROD_W-1:0] ORTHO_HALF = 128;
   localparam logic signed [PROD_W-1:0] SAT_HI =
      {{(PROD_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAT_LO =
      {{(PROD_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic [DEP_W-1:0]        rem;
      logic [QB-1:0]           nlo;
      logic [QB-1:0]           q;
      logic [DEP_W-1:0]        d;
      logic                    neg;
      logic                    pre;
      logic                    persp;
      logic signed [OUT_W-1:0] ores;
      logic                    oovf;
   } div_type;

   logic signed [PROD_W-1:0] prod_ff;
   logic [DEP_W-1:0]         d_ff;
   logic                     persp_ff;

   logic signed [PROD_W-1:0] o_full;
   logic signed [OUT_W-1:0]  o_res;
   logic                     o_ovf;
   logic [MAG_W-1:0]         mag;
   logic [NUM_W-1:0]         num, r0w;
   div_type                  div_p;

   div_type                  div_ff [QB+1];
   div_type                  div_in [QB];

   logic signed [OUT_W-1:0]  res_in, res_ff;
   logic                     ovf_in, ovf_ff;
   logic                     big;

   // stage m: scale by the field of view
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= coord_i * signed'({1'b0, fov_i});
         d_ff     <= depth_i;
         persp_ff <= persp_i;
      end
   end

   // stage p: orthographic result and divider setup
   always_comb begin
      o_full = (prod_ff + ORTHO_HALF) >>> 8;
      o_ovf  = 1'b0;
      if (o_full > SAT_HI) begin
         o_res = OUT_MAX;
         o_ovf = 1'b1;
      end else if (o_full < SAT_LO) begin
         o_res = OUT_MIN;
         o_ovf = 1'b1;
      end else begin
         o_res = OUT_W'(o_full);
      end
      mag = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
      num = {mag, {(COORD_FRAC_BITS-8){1'b0}}};
      r0w = num >> QB;
      div_p.rem   = DEP_W'(r0w);
      div_p.nlo   = num[QB-1:0];
      div_p.q     = '0;
      div_p.d     = d_ff;
      div_p.neg   = prod_ff[PROD_W-1];
      // quotient would not fit in the step count: clip
      div_p.pre   = r0w >= NUM_W'(d_ff);
      div_p.persp = persp_ff;
      div_p.ores  = o_res;
      div_p.oovf  = o_ovf;
   end

   // one restoring quotient bit per stage
   always_comb begin
      logic [DEP_W-1:0] t;
      logic             ge;
      for (int k = 0; k < QB; k++) begin
         t  = {div_ff[k].rem[DEP_W-2:0], div_ff[k].nlo[QB-1]};
         ge = t >= div_ff[k].d;
         div_in[k]     = div_ff[k];
         div_in[k].rem = ge ? t - div_ff[k].d : t;
         div_in[k].nlo = {div_ff[k].nlo[QB-2:0], 1'b0};
         div_in[k].q   = {div_ff[k].q[QB-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0] <= div_p;
         for (int k = 0; k < QB; k++) begin
            div_ff[k+1] <= div_in[k];
         end
      end
   end

   // stage f: sign and saturate
   always_comb begin
      big    = div_ff[QB].pre || div_ff[QB].q[QB-1];
      ovf_in = 1'b0;
      if (!div_ff[QB].persp) begin
         res_in = div_ff[QB].ores;
         ovf_in = div_ff[QB].oovf;
      end else if (!div_ff[QB].neg) begin
         if (big || div_ff[QB].q[OUT_W-1]) begin
            res_in = OUT_MAX;
            ovf_in = 1'b1;
         end else begin
            res_in = signed'(div_ff[QB].q[OUT_W-1:0]);
         end
      end else begin
         if (big || (div_ff[QB].q[OUT_W-1] && (div_ff[QB].q[OUT_W-2:0] != '0))) begin
            res_in = OUT_MIN;
            ovf_in = 1'b1;
         end else begin
            res_in = -signed'(div_ff[QB].q[OUT_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign result_o = res_ff;
   assign ovf_o    = ovf_ff;

endmodule

>>> design/vertex_rotate_and_project_core.sv
// pipeline: an accepted req item reaches rsp_tvalid through one input stage, three
//   two-stage rotations, then a 36-stage projection lane with a bit-per-stage divider
// throughput: one item per cycle while the skid entry is empty and sine/cosine are ready;
//   the output register and one skid entry behind it absorb a stall
// reset: synchronous, active high; registers return to their defaults and the trig
//   sequencer regenerates sine/cosine (also after any angle write), with req_tready low until it finishes
module vertex_rotate_and_project_core (
   input  logic                            clock,
   input  logic                            reset,
   // item in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [95:0]                     req_tdata,  // vertex_x, vertex_y, vertex_z
   // result out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata,  // screen_x, screen_y
   output logic [1:0]                      rsp_tuser,  // depth_invalid, overflowed
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vrp_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [vrp_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [vrp_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import vrp_pkg::*;

   // registers
   logic [ANGLE_REG_W-1:0] angle_x_ff, angle_y_ff, angle_z_ff;
   logic [FOV_W-1:0]       fov_ff;
   logic                   mode_ff;
   logic [CAM_W-1:0]       cam_ff;

   logic                   csr_wr;
   reg_index_type          csr_idx;
   logic                   angle_wr;
   angles_type             angles;
   trig_type               coefs;
   logic                   trig_ready;

   // pipeline control
   logic                   en;
   logic                   req_acc;
   logic [PIPE_LAT-1:0]    valid_ff;
   logic [LANE_LAT-1:0]    bad_ff;

   coord_type              vx_ff, vy_ff, vz_ff;
   coord_type              rx_a, rx_b, rx_p;   // y, z, x after x rotation
   coord_type              ry_a, ry_b, ry_p;   // x, z, y after y rotation
   coord_type              rz_a, rz_b, rz_p;   // x, y, z after z rotation
   logic signed [DEP_W-1:0] depth;
   logic                   bad_now;

   logic signed [OUT_W-1:0] lane_x, lane_y;
   logic                    ovf_x, ovf_y;
   result_type              res_last;

   // output register and skid
   result_type              out_ff, skid_ff;
   logic                    out_valid_ff, skid_valid_ff;
   logic                    out_take;

   // apb writes complete on the access cycle, pready tied high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign angle_wr   = csr_wr && (csr_idx == REG_ANGLE_X || csr_idx == REG_ANGLE_Y ||
                                  csr_idx == REG_ANGLE_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff <= '0;
         angle_y_ff <= '0;
         angle_z_ff <= '0;
         fov_ff     <= FOV_W'(174080);
         mode_ff    <= 1'b0;
         cam_ff     <= CAM_W'(5) << COORD_FRAC_BITS;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ANGLE_X:         angle_x_ff <= csr_pwdata[ANGLE_REG_W-1:0];
            REG_ANGLE_Y:         angle_y_ff <= csr_pwdata[ANGLE_REG_W-1:0];
            REG_ANGLE_Z:         angle_z_ff <= csr_pwdata[ANGLE_REG_W-1:0];
            REG_FOV_FACTOR:      fov_ff     <= csr_pwdata[FOV_W-1:0];
            REG_PROJECTION_MODE: mode_ff    <= csr_pwdata[0];
            REG_CAMERA_OFFSET:   cam_ff     <= csr_pwdata[CAM_W-1:0];
            default: ;  // addresses past the register list are ignored
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ANGLE_X:         csr_prdata = CSR_DW'(angle_x_ff);
         REG_ANGLE_Y:         csr_prdata = CSR_DW'(angle_y_ff);
         REG_ANGLE_Z:         csr_prdata = CSR_DW'(angle_z_ff);
         REG_FOV_FACTOR:      csr_prdata = CSR_DW'(fov_ff);
         REG_PROJECTION_MODE: csr_prdata = CSR_DW'(mode_ff);
         REG_CAMERA_OFFSET:   csr_prdata = CSR_DW'(cam_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // sine/cosine generation, runs after reset and after each angle write while intake is held
   assign angles.x = angle_x_ff;
   assign angles.y = angle_y_ff;
   assign angles.z = angle_z_ff;

   vrp_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .angles   (angles),
      .angle_wr (angle_wr),
      .coefs    (coefs),
      .ready    (trig_ready)
   );

   // the whole pipeline advances unless the skid entry is occupied
   assign en         = !skid_valid_ff;
   assign req_tready = en && trig_ready;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_acc};
      end
   end

   // input stage: sign extend to the rotation width
   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff <= COORD_W'(signed'(req_tdata[IN_W-1:0]));
         vy_ff <= COORD_W'(signed'(req_tdata[2*IN_W-1:IN_W]));
         vz_ff <= COORD_W'(signed'(req_tdata[3*IN_W-1:2*IN_W]));
      end
   end

   // rotate about x, then y, then z; a zero angle passes the pair unchanged
   vrp_rotate u_rot_x (
      .clock    (clock),
      .en       (en),
      .a_i      (vy_ff),
      .b_i      (vz_ff),
      .pass_i   (vx_ff),
      .cos_i    (coefs.cos_x),
      .sin_i    (coefs.sin_x),
      .bypass_i (angle_x_ff[ANGLE_BITS-1:0] == '0),
      .a_o      (rx_a),
      .b_o      (rx_b),
      .pass_o   (rx_p)
   );

   vrp_rotate u_rot_y (
      .clock    (clock),
      .en       (en),
      .a_i      (rx_p),
      .b_i      (rx_b),
      .pass_i   (rx_a),
      .cos_i    (coefs.cos_y),
      .sin_i    (coefs.sin_y),
      .bypass_i (angle_y_ff[ANGLE_BITS-1:0] == '0),
      .a_o      (ry_a),
      .b_o      (ry_b),
      .pass_o   (ry_p)
   );

   vrp_rotate u_rot_z (
      .clock    (clock),
      .en       (en),
      .a_i      (ry_a),
      .b_i      (ry_p),
      .pass_i   (ry_b),
      .cos_i    (coefs.cos_z),
      .sin_i    (coefs.sin_z),
      .bypass_i (angle_z_ff[ANGLE_BITS-1:0] == '0),
      .a_o      (rz_a),
      .b_o      (rz_b),
      .pass_o   (rz_p)
   );

   // perspective depth; in perspective mode a non-positive one forces a zero result
   assign depth   = DEP_W'(rz_p) + signed'(DEP_W'(cam_ff));
   assign bad_now = mode_ff && (depth <= 0);

   always_ff @(posedge clock) begin
      if (en) begin
         bad_ff <= {bad_ff[LANE_LAT-2:0], bad_now};
      end
   end

   vrp_lane u_lane_x (
      .clock    (clock),
      .en       (en),
      .coord_i  (rz_a),
      .depth_i  (depth),
      .persp_i  (mode_ff),
      .fov_i    (fov_ff),
      .result_o (lane_x),
      .ovf_o    (ovf_x)
   );

   vrp_lane u_lane_y (
      .clock    (clock),
      .en       (en),
      .coord_i  (rz_b),
      .depth_i  (depth),
      .persp_i  (mode_ff),
      .fov_i    (fov_ff),
      .result_o (lane_y),
      .ovf_o    (ovf_y)
   );

   always_comb begin
      if (bad_ff[LANE_LAT-1]) begin
         res_last.screen_x      = '0;
         res_last.screen_y      = '0;
         res_last.depth_invalid = 1'b1;
         res_last.overflowed    = 1'b0;
      end else begin
         res_last.screen_x      = lane_x;
         res_last.screen_y      = lane_y;
         res_last.depth_invalid = 1'b0;
         res_last.overflowed    = ovf_x || ovf_y;
      end
   end

   // output register with one skid entry behind it
   assign out_take = rsp_tready || !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= valid_ff[PIPE_LAT-1];
         end
      end else if (en && valid_ff[PIPE_LAT-1]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_ff <= skid_valid_ff ? skid_ff : res_last;
      end else if (en && valid_ff[PIPE_LAT-1]) begin
         skid_ff <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.screen_y, out_ff.screen_x};
   assign rsp_tuser  = {out_ff.overflowed, out_ff.depth_invalid};

endmodule

>>> design/vrp_checker.sv
module vrp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [63:0]                rsp_tdata,
   input logic [1:0]                 rsp_tuser,
   input logic                       csr_psel,
   input logic                       csr_penable,
   input logic                       csr_pwrite,
   input logic [vrp_pkg::CSR_AW-1:0] csr_paddr,
   input logic                       csr_pready
);
   import vrp_pkg::*;

   logic angle_write;
   assign angle_write = csr_psel && csr_penable && csr_pwrite &&
                        (csr_paddr[CSR_AW-1:2] == REG_ANGLE_X ||
                         csr_paddr[CSR_AW-1:2] == REG_ANGLE_Y ||
                         csr_paddr[CSR_AW-1:2] == REG_ANGLE_Z);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // invalid depth gives a zero point and no overflow
   a_bad_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("depth_invalid with nonzero result");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an angle write stops intake until sine/cosine are regenerated
   a_angle_stall: assert property (@(posedge clock) disable iff (reset)
      angle_write |=> !req_tready)
      else $error("item accepted with stale coefficients");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind vertex_rotate_and_project_core vrp_checker u_vrp_checker (.*);

>>> sim/vertex_rotate_and_project_core_tb.sv
module vertex_rotate_and_project_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vrp_pkg::*;

   typedef struct {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
   } vertex_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic        csr_pready;

   // pending vertices and the screen points they must produce
   vertex_item_type  vertex_queue[$];
   result_type       screen_queue[$];
   vertex_item_type  vertex_on_bus;
   int               error_count = 0;
   bit               no_idle = 0;
   int               send_gap = 0;
   int               recv_gap = 0;
   bit               hold_done = 0;
   int               hold_off = 0;

   // shadow copy of the configuration registers and derived trig values
   logic [15:0] sh_angle [3];
   logic [23:0] sh_fov;
   logic        sh_mode;
   logic [30:0] sh_cam;
   longint      sh_trig [6];
   bit          sh_trig_ok;

   vertex_rotate_and_project_core u_dut (.*);

   // clock, 10 ns period
   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // cordic sine / cosine for one angle, rounded to trig precision
   function automatic longint round_trig(input longint v);
      longint r;
      r = (v + (64'sd1 <<< (30 - TRIG_FRAC - 1))) >>> (30 - TRIG_FRAC);
      if (r > (64'sd1 <<< TRIG_FRAC)) r = 64'sd1 <<< TRIG_FRAC;
      if (r < -(64'sd1 <<< TRIG_FRAC)) r = -(64'sd1 <<< TRIG_FRAC);
      return r;
   endfunction

   task automatic cordic_sincos(input logic [15:0] ang, output longint cv, output longint sv);
      logic [31:0] a32;
      longint x, y, z, dx, dy, c, s;
      a32 = {ang, 16'h0000};
      z = longint'(a32[29:0]);
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_turn(STEP_W'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_turn(STEP_W'(i)));
         end
      end
      c = round_trig(x);
      s = round_trig(y);
      case (a32[31:30])
         2'd0: begin cv = c;  sv = s;  end
         2'd1: begin cv = -s; sv = c;  end
         2'd2: begin cv = -c; sv = -s; end
         default: begin cv = s; sv = -c; end
      endcase
   endtask

   function automatic longint clamp32(input longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin ovf = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin ovf = 1; return -64'sd2147483648; end
      return v;
   endfunction

   function automatic longint perspective_scale(input longint v, input longint depth,
                                                inout bit ovf);
      longint n;
      bit neg;
      logic [63:0] mag, d, q, rem;
      n = v * longint'(sh_fov);
      neg = n < 0;
      mag = neg ? -n : n;
      d = depth;
      q = mag / d;
      rem = mag % d;
      for (int i = 0; i < COORD_FRAC_BITS - 8; i++) begin
         if (q >= 64'h1_0000_0000) break;
         rem = rem << 1;
         q = q << 1;
         if (rem >= d) begin
            rem -= d; q[0] = 1'b1;
         end
      end
      if (q >= 64'h1_0000_0000) q = 64'h1_0000_0000;
      return clamp32(neg ? -longint'(q) : longint'(q), ovf);
   endfunction

   function automatic longint rot_round(input longint v);
      return (v + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
   endfunction

   // expected screen point for one vertex under the shadow configuration
   task automatic project_vertex(input vertex_item_type it, output result_type res);
      longint x, y, z, na, nb, sx, sy, depth;
      bit ovf, bad;
      x = longint'(signed'(it.vx));
      y = longint'(signed'(it.vy));
      z = longint'(signed'(it.vz));
      ovf = 0;
      bad = 0;
      if (!sh_trig_ok) begin
         for (int a = 0; a < 3; a++) cordic_sincos(sh_angle[a], sh_trig[2*a], sh_trig[2*a+1]);
         sh_trig_ok = 1;
      end
      // a zero angle bypasses its axis exactly
      if (sh_angle[0] != 0) begin
         na = rot_round(y * sh_trig[0] - z * sh_trig[1]);
         nb = rot_round(z * sh_trig[0] + y * sh_trig[1]);
         y = na; z = nb;
      end
      if (sh_angle[1] != 0) begin
         na = rot_round(x * sh_trig[2] - z * sh_trig[3]);
         nb = rot_round(z * sh_trig[2] + x * sh_trig[3]);
         x = na; z = nb;
      end
      if (sh_angle[2] != 0) begin
         na = rot_round(x * sh_trig[4] - y * sh_trig[5]);
         nb = rot_round(y * sh_trig[4] + x * sh_trig[5]);
         x = na; y = nb;
      end
      if (!sh_mode) begin
         sx = clamp32((x * longint'(sh_fov) + 128) >>> 8, ovf);
         sy = clamp32((y * longint'(sh_fov) + 128) >>> 8, ovf);
      end else begin
         depth = z + longint'(sh_cam);
         if (depth <= 0) begin
            bad = 1; sx = 0; sy = 0;
         end else begin
            sx = perspective_scale(x, depth, ovf);
            sy = perspective_scale(y, depth, ovf);
         end
      end
      res.screen_x = sx[31:0];
      res.screen_y = sy[31:0];
      res.depth_invalid = bad;
      res.overflowed = ovf;
   endtask

   // gap lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // input driver: takes vertices from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            result_type r;
            project_vertex(vertex_on_bus, r);
            screen_queue.push_back(r);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (vertex_queue.size() > 0) begin
            vertex_on_bus = vertex_queue.pop_front();
            req_tdata  <= {vertex_on_bus.vz, vertex_on_bus.vy, vertex_on_bus.vx};
            req_tvalid <= 1'b1;
            send_gap = no_idle ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off once, in the middle of a busy phase, so the pipeline
   // fills and stalls its input
   always @(posedge clock) begin
      if (!hold_done && vertex_queue.size() == 100) begin
         hold_off = 600;
         hold_done = 1;
      end else if (hold_off > 0) begin
         hold_off--;
      end
   end

   // output monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (screen_queue.size() == 0) begin
               $display("%0t: unexpected item x=%h y=%h user=%b", $realtime,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
               error_count++;
            end else begin
               result_type e;
               e = screen_queue.pop_front();
               if (rsp_tdata[31:0] !== e.screen_x) begin
                  $display("%0t: screen_x expected %h actual %h", $realtime,
                           e.screen_x, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[63:32] !== e.screen_y) begin
                  $display("%0t: screen_y expected %h actual %h", $realtime,
                           e.screen_y, rsp_tdata[63:32]);
                  error_count++;
               end
               if (rsp_tuser[0] !== e.depth_invalid) begin
                  $display("%0t: depth_invalid expected %b actual %b", $realtime,
                           e.depth_invalid, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tuser[1] !== e.overflowed) begin
                  $display("%0t: overflowed expected %b actual %b", $realtime,
                           e.overflowed, rsp_tuser[1]);
                  error_count++;
               end
            end
         end
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = no_idle ? 0 : pick_gap();
         end
      end
   end

   // register write over the apb port, shadow updated at the same edge
   task automatic write_reg(input reg_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * int'(idx));
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ANGLE_X: begin sh_angle[0] = val[15:0]; sh_trig_ok = 0; end
         REG_ANGLE_Y: begin sh_angle[1] = val[15:0]; sh_trig_ok = 0; end
         REG_ANGLE_Z: begin sh_angle[2] = val[15:0]; sh_trig_ok = 0; end
         REG_FOV_FACTOR: sh_fov = val[23:0];
         REG_PROJECTION_MODE: sh_mode = val[0];
         REG_CAMERA_OFFSET: sh_cam = val[30:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      if (r < 8) return $urandom;
      if (r == 8) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return 32'($signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200);
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h4000;
         3: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      vertex_item_type it;
      it.vx = x; it.vy = y; it.vz = z;
      vertex_queue.push_back(it);
   endtask

   // wait for the pipeline to drain, then let it idle before returning
   task automatic drain();
      while (vertex_queue.size() > 0 || screen_queue.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
   endtask

   initial begin
      int phase;
      logic [31:0] fov_val, cam_val;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      sh_angle[0] = 0; sh_angle[1] = 0; sh_angle[2] = 0;
      sh_fov = 24'd174080;
      sh_mode = 1'b0;
      sh_cam = 31'd327680;
      sh_trig_ok = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: default orthographic setup, field extremes
      queue_vertex(32'h0, 32'h0, 32'h0);
      queue_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      queue_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
      queue_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
      drain();

      // directed: perspective, depth exactly zero, negative and positive
      write_reg(REG_PROJECTION_MODE, 32'd1);
      queue_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFB_0000);
      queue_vertex(32'h0001_0000, 32'h0002_0000, 32'h8000_0000);
      queue_vertex(32'h0001_0000, 32'hFFFE_0000, 32'hFFFB_0001);
      queue_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFB_0001);
      queue_vertex(32'hFFFF_0000, 32'h0003_0000, 32'h7FFF_FFFF);
      drain();

      // directed: rotations on all axes, largest scale and offset
      write_reg(REG_ANGLE_X, 32'h0000_4000);
      write_reg(REG_ANGLE_Y, 32'h0000_8000);
      write_reg(REG_ANGLE_Z, 32'h0000_FFFF);
      write_reg(REG_FOV_FACTOR, 32'h00FF_FFFF);
      write_reg(REG_CAMERA_OFFSET, 32'h7FFF_FFFF);
      queue_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      drain();
      write_reg(REG_PROJECTION_MODE, 32'd0);
      write_reg(REG_FOV_FACTOR, 32'h0000_0000);
      queue_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      drain();
      write_reg(REG_CAMERA_OFFSET, 32'h0000_0000);
      write_reg(REG_PROJECTION_MODE, 32'd1);
      queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
      queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0000_0001);
      drain();

      // random phases, each under its own configuration
      for (phase = 0; phase < 10; phase++) begin
         no_idle = (phase % 4 == 1);
         write_reg(REG_ANGLE_X, {16'($urandom), rand_angle()});
         write_reg(REG_ANGLE_Y, {16'($urandom), rand_angle()});
         write_reg(REG_ANGLE_Z, {16'($urandom), rand_angle()});
         case ($urandom_range(0, 4))
            0: fov_val = 32'h00FF_FFFF;
            1: fov_val = 32'd0;
            2: fov_val = 32'd174080;
            default: fov_val = $urandom;
         endcase
         write_reg(REG_FOV_FACTOR, fov_val);
         write_reg(REG_PROJECTION_MODE, $urandom);
         case ($urandom_range(0, 4))
            0: cam_val = 32'hFFFF_FFFF;
            1: cam_val = 32'd0;
            2: cam_val = 32'd327680;
            default: cam_val = {1'($urandom_range(0, 1)),
                                31'($urandom_range(0, 32'h00FF_FFFF))};
         endcase
         write_reg(REG_CAMERA_OFFSET, cam_val);
         for (int n = 0; n < 160; n++) queue_vertex(rand_coord(), rand_coord(), rand_coord());
         drain();
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
